### sv/dotq_pkg.sv
// shared types and constants for the deadline ordered timer queue
// no dependencies; imported by dotq_cell and deadline_ordered_timer_queue
`default_nettype none
package dotq_pkg;

  localparam int QueueDepth = 16;
  localparam int IdBits     = 8;
  localparam int TimeBits   = 48;
  localparam int IntvBits   = 32;
  localparam int CntBits    = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    REQ_ADD = 2'd0,
    REQ_DEL = 2'd1,
    REQ_SVC = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_INIT = 2'd1,
    ST_DUP      = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_POP    = 2'd3
  } cell_cmd_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_SVC  = 2'd2
  } state_e;

  typedef struct packed {
    logic [TimeBits-1:0] deadline;
    logic [IdBits-1:0]   id;
  } entry_t;

  // command and operand broadcast to every cell
  typedef struct packed {
    cell_cmd_e cmd;
    entry_t    ent;
  } cell_bcast_t;

endpackage
`default_nettype wire

### sv/dotq_cell.sv
// one slot of the sorted timer chain: holds a deadline and id, shifts to neighbors
// depends on dotq_pkg
`default_nettype none
module dotq_cell (
  input  logic                 clk_i,
  input  dotq_pkg::cell_bcast_t bc_i,
  input  logic                 occ_i,
  input  logic                 left_le_i,
  input  dotq_pkg::entry_t     left_ent_i,
  input  dotq_pkg::entry_t     right_ent_i,
  input  logic                 pass_i,
  output logic                 le_o,
  output logic                 pass_o,
  output dotq_pkg::entry_t     ent_o
);
  import dotq_pkg::*;

  entry_t ent_q, ent_d;
  logic   hit;

  assign le_o   = occ_i && (ent_q.deadline <= bc_i.ent.deadline);
  assign hit    = occ_i && (ent_q.id == bc_i.ent.id);
  assign pass_o = pass_i | hit;
  assign ent_o  = ent_q;

  always_comb begin
    ent_d = ent_q;
    case (bc_i.cmd)
      CMD_INSERT: begin
        // entries later than the new deadline move one slot right
        if (!le_o) begin
          if (left_le_i) begin
            ent_d = bc_i.ent;
          end else begin
            ent_d = left_ent_i;
          end
        end
      end
      CMD_DELETE: begin
        if (pass_o) begin
          ent_d = right_ent_i;
        end
      end
      CMD_POP: begin
        ent_d = right_ent_i;
      end
      default: begin
        ent_d = ent_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule
`default_nettype wire

### sv/deadline_ordered_timer_queue.sv
// Sorted timer queue built from a chain of dotq_cell slots plus a request sequencer.
// Depends on dotq_pkg and dotq_cell.
//
// Usage: requests enter on the in_* valid/ready channel (add, delete or service),
// results leave on the out_* valid/ready channel, one beat per result, with
// last_o set on the final beat of each request. The user must write the enable
// register through cfg_we_i / cfg_wdata_i only while the block is idle; the
// block does not enforce this. A request is taken when in_ready_o is high, which
// is only while the sequencer is idle. Add and delete load their result beat
// from S_EXEC after one compare-and-shift across the cell chain; a new request
// is taken only once that beat is loaded. Service loads F + 1 beats for F fired
// timers, one per cycle while the receiver does not stall, as the chain pops one
// head entry per beat; the final beat carries sleep_us_o, and the next request
// is taken only once it is loaded. The result sits in an output register; if the
// receiver stalls, the sequencer and the cell chain hold until the beat is taken.
// Reset clears the entry count (queue empty), the enable bit, the sequencer and
// the output valid; cell contents are not cleared and are never read while empty.
`default_nettype none
module deadline_ordered_timer_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    req_type_i,
  input  logic [dotq_pkg::IdBits-1:0]   entry_id_i,
  input  logic [dotq_pkg::IntvBits-1:0] interval_us_i,
  input  logic [dotq_pkg::TimeBits-1:0] time_now_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic                          was_deleted_o,
  output logic                          fired_valid_o,
  output logic [dotq_pkg::IdBits-1:0]   fired_id_o,
  output logic [dotq_pkg::TimeBits-1:0] sleep_us_o,
  output logic                          last_o
);
  import dotq_pkg::*;

  state_e               state_q, state_d;
  logic [CntBits-1:0]   count_q, count_d;
  logic                 enable_q;
  logic [1:0]           req_q;
  logic [IdBits-1:0]    id_q;
  logic [TimeBits-1:0]  now_q;
  logic [TimeBits-1:0]  dl_q;
  logic [TimeBits:0]    dl_sum;

  logic                 out_valid_q;
  logic [1:0]           status_q, status_d;
  logic                 del_q, del_d;
  logic                 fv_q, fv_d;
  logic [IdBits-1:0]    fid_q, fid_d;
  logic [TimeBits-1:0]  sleep_q, sleep_d;
  logic                 last_q, last_d;
  logic                 load;

  cell_bcast_t          bc;
  entry_t               ent  [QueueDepth];
  logic                 occ  [QueueDepth];
  logic                 le   [QueueDepth];
  logic                 pass [QueueDepth];

  logic                 out_free;
  logic                 head_fire;
  logic                 found;
  logic                 full;
  logic                 in_fire;

  // cell chain
  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    logic   left_le;
    entry_t left_ent;
    entry_t right_ent;
    logic   pass_in;

    if (i == 0) begin : g_first
      assign left_le  = 1'b1;
      assign left_ent = ent[i];
      assign pass_in  = 1'b0;
    end else begin : g_mid
      assign left_le  = le[i-1];
      assign left_ent = ent[i-1];
      assign pass_in  = pass[i-1];
    end
    if (i == QueueDepth - 1) begin : g_last
      assign right_ent = ent[i];
    end else begin : g_inner
      assign right_ent = ent[i+1];
    end

    assign occ[i] = count_q > CntBits'(i);

    dotq_cell u_cell (
      .clk_i       (clk_i),
      .bc_i        (bc),
      .occ_i       (occ[i]),
      .left_le_i   (left_le),
      .left_ent_i  (left_ent),
      .right_ent_i (right_ent),
      .pass_i      (pass_in),
      .le_o        (le[i]),
      .pass_o      (pass[i]),
      .ent_o       (ent[i])
    );
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign head_fire  = occ[0] && (ent[0].deadline < now_q);
  assign found      = pass[QueueDepth-1];
  assign full       = (count_q == CntBits'(QueueDepth));

  // saturating deadline
  assign dl_sum = {1'b0, time_now_i} + {{(TimeBits + 1 - IntvBits){1'b0}}, interval_us_i};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (req_type_i == REQ_SVC) ? S_SVC : S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_SVC: begin
        if (out_free && !head_fire) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // chain commands and result beat
  always_comb begin
    bc.cmd          = CMD_HOLD;
    bc.ent.deadline = dl_q;
    bc.ent.id       = id_q;
    count_d         = count_q;
    load            = 1'b0;
    status_d        = ST_OK;
    del_d           = 1'b0;
    fv_d            = 1'b0;
    fid_d           = '0;
    sleep_d         = '0;
    last_d          = 1'b1;
    unique case (state_q)
      S_EXEC: begin
        if (out_free) begin
          load = 1'b1;
          unique case (req_q)
            REQ_ADD: begin
              if (!enable_q) begin
                status_d = ST_NOT_INIT;
              end else if (found) begin
                status_d = ST_DUP;
              end else if (full) begin
                status_d = ST_FULL;
              end else begin
                bc.cmd  = CMD_INSERT;
                count_d = count_q + CntBits'(1);
              end
            end
            REQ_DEL: begin
              if (!enable_q) begin
                status_d = ST_NOT_INIT;
              end else if (found) begin
                bc.cmd  = CMD_DELETE;
                del_d   = 1'b1;
                count_d = count_q - CntBits'(1);
              end
            end
            default: begin
              status_d = ST_OK;
            end
          endcase
        end
      end
      S_SVC: begin
        if (out_free) begin
          load = 1'b1;
          if (head_fire) begin
            bc.cmd  = CMD_POP;
            fv_d    = 1'b1;
            fid_d   = ent[0].id;
            last_d  = 1'b0;
            count_d = count_q - CntBits'(1);
          end else if (enable_q && occ[0]) begin
            sleep_d = ent[0].deadline - now_q;
          end
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      enable_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= req_type_i;
      id_q  <= entry_id_i;
      now_q <= time_now_i;
      dl_q  <= dl_sum[TimeBits] ? {TimeBits{1'b1}} : dl_sum[TimeBits-1:0];
    end
    if (load) begin
      status_q <= status_d;
      del_q    <= del_d;
      fv_q     <= fv_d;
      fid_q    <= fid_d;
      sleep_q  <= sleep_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign was_deleted_o = del_q;
  assign fired_valid_o = fv_q;
  assign fired_id_o    = fid_q;
  assign sleep_us_o    = sleep_q;
  assign last_o        = last_q;

endmodule
`default_nettype wire
